>>> sv/rmsblur_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the RMS box blur block: field widths, register indexes,
// operation codes and default store limits. No dependencies.
package rmsblur_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 15;

  localparam int PIX_W      = 8;
  localparam int RAD_W      = 4;   // blur_radius register
  localparam int SIZE_REG_W = 9;   // frame_width / frame_height registers
  localparam int CNT_W      = 5;   // window offset 0 .. 2*R
  localparam int SIDE_W     = 5;   // 2R+1
  localparam int SIDE_SQ_W  = 10;  // (2R+1)^2

  localparam int SQ_SUM_W    = 26;
  localparam int ALPHA_SUM_W = 18;

  // shared subtract unit
  localparam int UNIT_W          = 17;
  localparam int ACC_W           = 18;
  localparam int ROOT_W          = SQ_SUM_W / 2;
  localparam int STEP_W          = 5;
  localparam int ROOT_STEPS      = SQ_SUM_W / 2;
  localparam int ALPHA_DIV_STEPS = ALPHA_SUM_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLUR_RADIUS  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [RAD_W-1:0]      RADIUS_RST = 4'd1;
  localparam logic [SIZE_REG_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [SIZE_REG_W-1:0] HEIGHT_RST = 9'd256;

endpackage

>>> sv/rms_box_blur_reflect.sv
`timescale 1ns / 1ps
// RMS box blur over a stored RGBA frame with mirrored borders.
// Top level; depends on rmsblur_pkg.
//
// A load beat (tuser 0) writes one pixel into the frame store and returns
// nothing. A query beat (tuser 1) returns one beat: the root of the mean of
// squares of red, green and blue and the plain mean of alpha over the
// (2R+1)x(2R+1) mirrored window. A query holds the input through the window
// walk, paced by the one read port of the frame store, then through the work
// on one shared trial-subtract unit (three 13-step square roots, three
// 13-step divides by 2R+1, one 18-step divide by (2R+1)^2), and through the
// handoff to the output register. A finished result sits in the output
// register, so the next item is taken while it waits. The store has no
// reset; a query must only cover pixels that have been loaded. Configuration
// writes take effect at the next query.
module rms_box_blur_reflect
  import rmsblur_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [47:0]            s_tdata,  // col, row, in_red, in_green, in_blue, in_alpha
  input  logic                   s_tuser,  // operation
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [31:0]            m_tdata,  // out_red, out_green, out_blue, out_alpha
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WSW   = $clog2(MAX_WIDTH + 1);
  localparam int HSW   = $clog2(MAX_HEIGHT + 1);
  localparam int CMAX  = (XW > YW) ? XW : YW;
  localparam int ZW    = ((CMAX > PIX_W) ? CMAX : PIX_W) + 3;

  localparam logic signed [ZW-1:0] ONE_Z  = 1;
  localparam logic signed [ZW-1:0] ZERO_Z = 0;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_DRAIN, S_ROOT, S_DIV, S_FIN
  } state_t;

  // mirror a window coordinate into [0, size-1]
  function automatic logic [ZW-1:0] reflect(input logic signed [ZW-1:0] z,
                                            input logic signed [ZW-1:0] sz);
    logic signed [ZW-1:0] m;
    if (z >= sz) begin
      m = sz + sz - z - ONE_Z;
    end else if (z >= ZERO_Z) begin
      m = z;
    end else begin
      m = ZERO_Z - z;
    end
    if (m < ZERO_Z) begin
      m = ZERO_Z;
    end
    if (m > sz - ONE_Z) begin
      m = sz - ONE_Z;
    end
    return m;
  endfunction

  // configuration registers
  logic [RAD_W-1:0]      blur_radius;
  logic [SIZE_REG_W-1:0] frame_width;
  logic [SIZE_REG_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_radius  <= RADIUS_RST;
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLUR_RADIUS:  blur_radius  <= cfg_data[RAD_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[SIZE_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated frame size and radius
  logic [WSW-1:0]       w_eff;
  logic [HSW-1:0]       h_eff;
  logic [RAD_W-1:0]     rad_eff;
  logic [SIDE_W-1:0]    side_c;
  logic [SIDE_SQ_W-1:0] side_ext;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WSW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WSW'(MAX_WIDTH);
    end else begin
      w_eff = WSW'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = HSW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = HSW'(MAX_HEIGHT);
    end else begin
      h_eff = HSW'(frame_height);
    end
    rad_eff  = (32'(blur_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : blur_radius;
    side_c   = {rad_eff, 1'b1};
    side_ext = SIDE_SQ_W'(side_c);
  end

  // input fields
  logic [PIX_W-1:0] in_col, in_row;
  logic [31:0]      in_pixel;
  assign in_col   = s_tdata[7:0];
  assign in_row   = s_tdata[15:8];
  assign in_pixel = s_tdata[47:16];

  // sequencer state and datapath registers
  state_t               state;
  logic [PIX_W-1:0]     col_q, row_q;
  logic [WSW-1:0]       w_q;
  logic [HSW-1:0]       h_q;
  logic [RAD_W-1:0]     rad_q;
  logic [SIDE_W-1:0]    side_q;
  logic [SIDE_SQ_W-1:0] side_sq_q;
  logic [CNT_W-1:0]     cx, cy;
  logic                 va, vb, vc;
  logic [XW-1:0]        ex_q;
  logic [YW-1:0]        ey_q;
  logic [AW-1:0]        rd_addr;
  logic [31:0]          rd_data;
  logic [SQ_SUM_W-1:0]    sum_r, sum_g, sum_b;
  logic [ALPHA_SUM_W-1:0] sum_a;
  logic [SQ_SUM_W-1:0]    num;
  logic [UNIT_W-1:0]      rem;
  logic [ACC_W-1:0]       acc;
  logic [STEP_W-1:0]      steps;
  logic [SIDE_SQ_W-1:0]   dsr;
  logic [1:0]             job;
  logic [PIX_W-1:0]       res [4];

  logic s_fire, load_fire, query_fire, load_in_store;
  assign s_tready   = (state == S_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign load_fire  = s_fire && (s_tuser == OP_LOAD);
  assign query_fire = s_fire && (s_tuser == OP_QUERY);
  assign load_in_store = (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);

  // window walk address generation
  logic [CNT_W-1:0]     span;
  logic signed [ZW-1:0] zx, zy;
  logic                 walk_last;
  assign span      = {rad_q, 1'b0};
  assign zx        = ZW'(col_q) - ZW'(rad_q) + ZW'(cx);
  assign zy        = ZW'(row_q) - ZW'(rad_q) + ZW'(cy);
  assign walk_last = (cx == span) && (cy == span);

  logic [15:0] sq_r, sq_g, sq_b;
  assign sq_r = 16'(rd_data[7:0])   * 16'(rd_data[7:0]);
  assign sq_g = 16'(rd_data[15:8])  * 16'(rd_data[15:8]);
  assign sq_b = 16'(rd_data[23:16]) * 16'(rd_data[23:16]);

  // shared trial-subtract unit: one root digit or one quotient bit a cycle
  logic              root_mode;
  logic [UNIT_W-1:0] op_a, op_b, diff;
  logic              ge;
  assign root_mode = (state == S_ROOT);
  always_comb begin
    if (root_mode) begin
      op_a = {rem[UNIT_W-3:0], num[SQ_SUM_W-1 -: 2]};
      op_b = {acc[UNIT_W-3:0], 2'b01};
    end else begin
      op_a = {rem[UNIT_W-2:0], num[SQ_SUM_W-1]};
      op_b = UNIT_W'(dsr);
    end
    diff = op_a - op_b;
    ge   = (op_a >= op_b);
  end

  logic [SQ_SUM_W-1:0] next_sum;
  always_comb begin
    unique case (job)
      2'd0:    next_sum = sum_g;
      2'd1:    next_sum = sum_b;
      default: next_sum = sum_r;
    endcase
  end

  logic step_last;
  assign step_last = (steps == STEP_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      m_tvalid <= 1'b0;
      cx       <= '0;
      cy       <= '0;
      job      <= '0;
      steps    <= '0;
      sum_r    <= '0;
      sum_g    <= '0;
      sum_b    <= '0;
      sum_a    <= '0;
    end else begin
      vb <= va;
      vc <= vb;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      rd_addr <= AW'(ey_q) * AW'(MAX_WIDTH) + AW'(ex_q);
      if (vc) begin
        sum_r <= sum_r + SQ_SUM_W'(sq_r);
        sum_g <= sum_g + SQ_SUM_W'(sq_g);
        sum_b <= sum_b + SQ_SUM_W'(sq_b);
        sum_a <= sum_a + ALPHA_SUM_W'(rd_data[31:24]);
      end
      unique case (state)
        S_IDLE: begin
          va <= 1'b0;
          if (query_fire) begin
            col_q     <= in_col;
            row_q     <= in_row;
            w_q       <= w_eff;
            h_q       <= h_eff;
            rad_q     <= rad_eff;
            side_q    <= side_c;
            side_sq_q <= SIDE_SQ_W'(side_ext * side_ext);
            cx        <= '0;
            cy        <= '0;
            sum_r     <= '0;
            sum_g     <= '0;
            sum_b     <= '0;
            sum_a     <= '0;
            state     <= S_WALK;
          end
        end
        S_WALK: begin
          va   <= 1'b1;
          ex_q <= XW'(reflect(zx, ZW'(w_q)));
          ey_q <= YW'(reflect(zy, ZW'(h_q)));
          if (cx == span) begin
            cx <= '0;
            cy <= cy + CNT_W'(1);
          end else begin
            cx <= cx + CNT_W'(1);
          end
          if (walk_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          va <= 1'b0;
          if (!va && !vb && !vc) begin
            num   <= sum_r;
            rem   <= '0;
            acc   <= '0;
            steps <= STEP_W'(ROOT_STEPS);
            job   <= '0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          num   <= num << 2;
          rem   <= ge ? diff : op_a;
          acc   <= {acc[ACC_W-2:0], ge};
          steps <= steps - STEP_W'(1);
          if (step_last) begin
            // divide the root by the window side
            num   <= {acc[ROOT_W-2:0], ge, ROOT_W'(0)};
            rem   <= '0;
            acc   <= '0;
            dsr   <= SIDE_SQ_W'(side_q);
            steps <= STEP_W'(ROOT_STEPS);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          num   <= num << 1;
          rem   <= ge ? diff : op_a;
          acc   <= {acc[ACC_W-2:0], ge};
          steps <= steps - STEP_W'(1);
          if (step_last) begin
            res[job] <= {acc[PIX_W-2:0], ge};
            job      <= job + 2'd1;
            rem      <= '0;
            acc      <= '0;
            if (job == 2'd3) begin
              state <= S_FIN;
            end else if (job == 2'd2) begin
              num   <= {sum_a, (SQ_SUM_W - ALPHA_SUM_W)'(0)};
              dsr   <= side_sq_q;
              steps <= STEP_W'(ALPHA_DIV_STEPS);
            end else begin
              num   <= next_sum;
              steps <= STEP_W'(ROOT_STEPS);
              state <= S_ROOT;
            end
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res[3], res[2], res[1], res[0]};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // frame store
  logic [31:0] mem [DEPTH];
  logic [AW-1:0] wr_addr;
  assign wr_addr = AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col);

  always_ff @(posedge clk) begin
    if (load_fire && load_in_store) begin
      mem[wr_addr] <= in_pixel;
    end
    rd_data <= mem[rd_addr];
  end

  // checks
  a_pipe_in_walk: assert property (@(posedge clk) disable iff (rst)
    (va || vb || vc) |-> (state == S_WALK || state == S_DRAIN))
    else $error("window pipeline active outside walk");

  a_coord_in_frame: assert property (@(posedge clk) disable iff (rst)
    va |-> (WSW'(ex_q) < w_q && HSW'(ey_q) < h_q))
    else $error("mirrored coordinate outside frame");

  a_walk_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> (cx <= span && cy <= span))
    else $error("window counter past span");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_fire |=> !s_tready)
    else $error("query accepted but block not busy");

  a_fin_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!m_tvalid || m_tready)) |=> (m_tvalid && state == S_IDLE))
    else $error("finished result not handed to output");

endmodule

>>> tb/rms_box_blur_reflect_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for rms_box_blur_reflect: pixel loads and window queries
// checked against an in-bench model of the mirrored RMS box blur. Depends on rmsblur_pkg.
module rms_box_blur_reflect_test;
  import rmsblur_pkg::*;

  typedef struct packed {
    bit [7:0] alpha;
    bit [7:0] blue;
    bit [7:0] green;
    bit [7:0] red;
    bit [7:0] row;
    bit [7:0] col;
  } pix_fields_t;

  typedef struct packed {
    logic        op;
    pix_fields_t f;
  } pix_beat_t;

  typedef struct packed {
    bit [7:0] alpha;
    bit [7:0] blue;
    bit [7:0] green;
    bit [7:0] red;
  } rgba_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [47:0]           s_tdata = '0;  // col, row, in_red, in_green, in_blue, in_alpha
  logic                  s_tuser = 1'b0;  // operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;  // out_red, out_green, out_blue, out_alpha
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BLUR_RADIUS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rms_box_blur_reflect uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // model state
  bit [31:0]       frame_img [0:65535];
  bit              px_loaded [0:65535];  // what the generator has already loaded
  bit [RAD_W-1:0]  radius_reg = RADIUS_RST;
  bit [8:0]        width_reg  = WIDTH_RST;
  bit [8:0]        height_reg = HEIGHT_RST;

  pix_beat_t pend_beats[$];
  rgba_t     blurred_px_q[$];
  int        n_pushed   = 0;
  int        n_accepted = 0;
  int        n_bad      = 0;
  int        rnd_items  = 0;
  int        gap_pct    = 14;
  int        stall_pct  = 14;
  bit        hold_arm   = 1'b0;

  function automatic int eff_size(bit [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function automatic int mirror_coord(int z, int size);
    int m;
    if (z >= size) m = 2 * size - z - 1;
    else if (z < 0) m = -z;
    else m = z;
    if (m < 0) m = 0;
    if (m > size - 1) m = size - 1;
    return m;
  endfunction

  function automatic int unsigned root_floor(int unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return int'(r);
  endfunction

  function automatic rgba_t window_blur(int c, int r);
    int          w;
    int          h;
    int          rad;
    int          ey;
    int          ex;
    int unsigned sr;
    int unsigned sg;
    int unsigned sb;
    int unsigned sa;
    int unsigned side;
    bit [31:0]   px;
    rgba_t       o;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    rad = int'(radius_reg);
    side = 2 * rad + 1;
    sr = 0; sg = 0; sb = 0; sa = 0;
    for (int dy = -rad; dy <= rad; dy++) begin
      ey = mirror_coord(r + dy, h);
      for (int dx = -rad; dx <= rad; dx++) begin
        ex = mirror_coord(c + dx, w);
        px = frame_img[ey * 256 + ex];
        sr += px[7:0] * px[7:0];
        sg += px[15:8] * px[15:8];
        sb += px[23:16] * px[23:16];
        sa += px[31:24];
      end
    end
    o.red   = 8'(root_floor(sr) / side);
    o.green = 8'(root_floor(sg) / side);
    o.blue  = 8'(root_floor(sb) / side);
    o.alpha = 8'(sa / (side * side));
    return o;
  endfunction

  function automatic void apply_beat(pix_beat_t b);
    if (b.op == OP_LOAD)
      frame_img[{b.f.row, b.f.col}] = {b.f.alpha, b.f.blue, b.f.green, b.f.red};
    else
      blurred_px_q.push_back(window_blur(b.f.col, b.f.row));
  endfunction

  // sender
  pix_beat_t held_beat;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_beat(held_beat);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pend_beats.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          held_beat = pend_beats.pop_front();
          s_tdata  <= held_beat.f;
          s_tuser  <= held_beat.op;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver; one long hold-off when armed
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= 1500;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : result_chk
    rgba_t want;
    rgba_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (blurred_px_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result beat %h", m_tdata);
      end else begin
        want = blurred_px_q.pop_front();
        if (got != want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("result mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                     want.red, want.green, want.blue, want.alpha,
                     got.red, got.green, got.blue, got.alpha);
        end
      end
    end
  end

  task automatic push_beat(logic op, int c, int r, int red, int grn, int blu, int alp);
    pix_beat_t b;
    b.op = op;
    b.f.col = 8'(c);
    b.f.row = 8'(r);
    b.f.red = 8'(red);
    b.f.green = 8'(grn);
    b.f.blue = 8'(blu);
    b.f.alpha = 8'(alp);
    if (op == OP_LOAD) px_loaded[{b.f.row, b.f.col}] = 1'b1;
    pend_beats.push_back(b);
    n_pushed++;
  endtask

  task automatic push_load_rand(int c, int r);
    push_beat(OP_LOAD, c, r, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // loads any window pixel not yet written, then the query itself
  task automatic push_query(int c, int r);
    int w;
    int h;
    int rad;
    int ey;
    int ex;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    rad = int'(radius_reg);
    for (int dy = -rad; dy <= rad; dy++) begin
      ey = mirror_coord(r + dy, h);
      for (int dx = -rad; dx <= rad; dx++) begin
        ex = mirror_coord(c + dx, w);
        if (!px_loaded[ey * 256 + ex]) push_load_rand(ex, ey);
      end
    end
    push_beat(OP_QUERY, c, r, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (n_accepted != n_pushed || blurred_px_q.size() != 0);
    // trailing loads may still be in flight
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [8:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_BLUR_RADIUS:  radius_reg = val[RAD_W-1:0];
      REG_FRAME_WIDTH:  width_reg  = val;
      REG_FRAME_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_config(bit [8:0] rad, bit [8:0] w, bit [8:0] h);
    wait_idle();
    write_reg(REG_BLUR_RADIUS, rad);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int quota, int query_pct);
    int w;
    int h;
    int start;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    while (quota > 0) begin
      start = n_pushed;
      if ($urandom_range(0, 99) >= query_pct) begin
        if ($urandom_range(0, 9) < 7)
          push_load_rand($urandom_range(0, w - 1), $urandom_range(0, h - 1));
        else
          push_load_rand($urandom_range(0, 255), $urandom_range(0, 255));
      end else if ($urandom_range(0, 99) < 85) begin
        push_query($urandom_range(0, w - 1), $urandom_range(0, h - 1));
      end else begin
        push_query($urandom_range(0, 255), $urandom_range(0, 255));
      end
      quota -= n_pushed - start;
      rnd_items += n_pushed - start;
    end
  endtask

  task automatic random_config();
    int       kind;
    int       rsel;
    bit [3:0] rad;
    bit [8:0] w;
    bit [8:0] h;
    kind = $urandom_range(0, 9);
    rad = 4'($urandom_range(0, 15));
    case (kind)
      0: begin
        w = 9'($urandom_range(256, 511));
        h = 9'($urandom_range(0, 1));
      end
      1: begin
        w = 9'($urandom_range(0, 1));
        h = 9'($urandom_range(256, 511));
      end
      2: begin
        // big frame, so keep the window tiny
        w = 9'($urandom_range(200, 511));
        h = 9'($urandom_range(200, 511));
        rad = 4'($urandom_range(0, 1));
      end
      default: begin
        w = 9'($urandom_range(16, 20));
        h = 9'($urandom_range(16, 20));
        rsel = $urandom_range(0, 3);
        if (rsel == 0) rad = 4'd0;
        else if (rsel == 1) rad = 4'd15;
      end
    endcase
    // upper data bits are beyond the radius register
    set_config({5'($urandom_range(0, 31)), rad}, w, h);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // single-pixel window, extremes and a centre past the frame edge
    set_config(9'd0, 9'd16, 9'd16);
    push_beat(OP_LOAD, 0, 0, 255, 255, 255, 255);
    push_beat(OP_LOAD, 15, 15, 0, 0, 0, 0);
    push_beat(OP_LOAD, 255, 255, 8'ha5, 8'h5a, 8'h0f, 8'hf0);
    push_beat(OP_LOAD, 15, 0, 8'h80, 8'h7f, 8'h01, 8'hfe);
    push_query(0, 0);
    push_query(15, 15);
    push_query(255, 255);
    push_query(15, 0);

    // frame clamps to one pixel, radius far beyond it: largest sums
    set_config(9'd15, 9'd0, 9'd0);
    push_query(0, 0);
    push_query(200, 100);

    // width saturates at the store width
    set_config(9'd2, 9'd511, 9'd1);
    push_query(255, 0);
    push_query(0, 0);

    // height saturates, width clamps to one column
    set_config(9'd1, 9'd1, 9'd300);
    push_query(0, 255);
    push_query(0, 0);

    // widest window over a 16x16 frame
    set_config({5'($urandom_range(0, 31)), 4'd15}, 9'd16, 9'd16);
    random_phase(60, 70);

    // long output hold-off while queries keep coming
    set_config(9'd1, 9'd16, 9'd16);
    hold_arm = 1'b1;
    random_phase(50, 85);

    // stretch without any idling on either side
    random_config();
    gap_pct = 0;
    stall_pct = 0;
    random_phase(60, 70);

    while (rnd_items < 580) begin
      random_config();
      gap_pct = 14;
      stall_pct = 14;
      random_phase($urandom_range(30, 80), 65);
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (n_bad == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
